// ===== rtl/csmabs_pkg.sv =====
// ----------------------------------------------------------------------------
// csmabs_pkg
// Shared types, codes and arithmetic helpers of the CSMA backoff station.
// ----------------------------------------------------------------------------
package csmabs_pkg;

  localparam logic [1:0] OP_ARRIVE  = 2'd0;
  localparam logic [1:0] OP_CHECK   = 2'd1;
  localparam logic [1:0] OP_OUTCOME = 2'd2;

  localparam logic [1:0] REG_MAX_RETRIES = 2'd0;
  localparam logic [1:0] REG_SEED        = 2'd1;
  localparam logic [1:0] REG_ERR_THRESH  = 2'd2;

  localparam logic [30:0] PM_MOD = 31'd2147483647;
  localparam logic [30:0] PM_A1  = 31'd16807;
  localparam logic [30:0] PM_A2  = 31'd282475249;

  localparam logic [3:0]  MAX_RETRIES_RST = 4'd5;
  localparam logic [30:0] SEED_RST        = 31'd1;
  localparam logic [30:0] ERR_THRESH_RST  = 31'd2147484;
  localparam logic [4:0]  RETRY_SAT       = 5'd31;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_DROP_FULL  = 3'd2,
    ST_TX_START   = 3'd3,
    ST_DELIVERED  = 3'd4,
    ST_DROP_LIMIT = 3'd5,
    ST_RETRY      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_BACKOFF = 2'd1,
    PH_TX      = 2'd2
  } phase_t;

  // x * a mod 2^31-1 by folding the high half onto the low half
  function automatic logic [30:0] pm_mulmod(logic [30:0] x, logic [30:0] a);
    logic [61:0] prod;
    logic [31:0] fold;
    prod = 62'(x) * 62'(a);
    fold = {1'b0, prod[30:0]} + {1'b0, prod[61:31]};
    if (fold >= {1'b0, PM_MOD}) begin
      fold = fold - {1'b0, PM_MOD};
    end
    return fold[30:0];
  endfunction

  // (c << shift) mod w by shift and conditional subtract, elaboration only
  function automatic logic [10:0] chunk_mod(int unsigned c, int unsigned shift,
                                            int unsigned w);
    longint unsigned val;
    longint unsigned r;
    val = longint'(c) << shift;
    r = 0;
    for (int i = 39; i >= 0; i--) begin
      r = 2 * r + ((val >> i) & 1);
      if (r >= w) begin
        r = r - w;
      end
    end
    return 11'(r);
  endfunction

endpackage

// ===== rtl/csma_backoff_station_unit.sv =====
// ----------------------------------------------------------------------------
// csma_backoff_station_unit
// Transmit side of a CSMA station: tag queue, random backoff, retry control.
// ----------------------------------------------------------------------------
// One word enters the input register, is worked in a single pass and lands in
// the result register; a word is taken in every cycle while the result side
// keeps up. The Park-Miller generator runs two values ahead in registers so
// the bit-error test, the backoff draw and the next lookahead all come from
// one multiply stage; after reset or a write of the seed register the
// lookahead reloads from the seed. Backoff values are reduced modulo the
// window through constant byte tables. The tag queue is a memory with a
// registered head read; it needs no clearing pass.
module csma_backoff_station_unit #(
  parameter int QUEUE_DEPTH    = 10,
  parameter int BACKOFF_WINDOW = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // packet_tag[15:0], channel_busy[16], collided[17], zero
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // tx_tag[15:0], tx_is_retry[16], queue_count[20:17],
                                 // retries_now[25:21], zero
  output logic [2:0]  m_tuser,   // status[2:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int BW = $clog2(BACKOFF_WINDOW + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
  localparam logic [BW+1:0] WIN_X1   = (BW + 2)'(BACKOFF_WINDOW);
  localparam logic [BW+1:0] WIN_X2   = (BW + 2)'(2 * BACKOFF_WINDOW);

  // configuration
  logic [3:0]  max_retries;
  logic [30:0] seed;
  logic [30:0] err_thresh;
  logic        pm_reload;

  // input register
  logic        in_full;
  logic [1:0]  in_op;
  logic [15:0] in_tag;
  logic        in_busy;
  logic        in_coll;

  // result register
  logic                  out_full;
  csmabs_pkg::status_t   out_status;
  logic [15:0]           out_tag;
  logic                  out_retry;
  logic [3:0]            out_count;
  logic [4:0]            out_retries;

  // station state
  logic [PW-1:0]       head_ptr, head_ptr_next;
  logic [PW-1:0]       tail_ptr, tail_ptr_next;
  logic [CW-1:0]       held_count, held_count_next;
  logic [4:0]          retry_count, retry_count_next;
  logic [BW-1:0]       backoff_left, backoff_left_next;
  csmabs_pkg::phase_t  phase, phase_next;
  logic [30:0]         pm_la1, pm_la2;
  logic [15:0]         tag_mem [QUEUE_DEPTH];
  logic [15:0]         head_tag;

  logic                proc;
  logic                tag_wr;
  logic [1:0]          pm_steps;
  csmabs_pkg::status_t status;
  logic [15:0]         tag_out;
  logic                is_retry;
  logic [4:0]          retry_inc;
  logic                failed;
  logic [30:0]         pm_src, pm_m1, pm_m2;

  logic [BW-1:0] mod_tab [4][256];
  logic [BW+1:0] mod_sum [2];
  logic [BW-1:0] draw_val [2];
  logic [30:0]   la_val [2];

  assign proc     = in_full && (!out_full || m_tready);
  assign s_tready = !rst && (!in_full || proc);

  // constant residue tables, one per byte of the generator value
  for (genvar gi = 0; gi < 4; gi++) begin : g_tab
    for (genvar gc = 0; gc < 256; gc++) begin : g_ent
      assign mod_tab[gi][gc] = BW'(csmabs_pkg::chunk_mod(gc, 8 * gi, BACKOFF_WINDOW));
    end
  end

  assign la_val[0] = pm_la1;
  assign la_val[1] = pm_la2;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mod_sum[l] = (BW + 2)'(mod_tab[0][la_val[l][7:0]])
                 + (BW + 2)'(mod_tab[1][la_val[l][15:8]])
                 + (BW + 2)'(mod_tab[2][la_val[l][23:16]])
                 + (BW + 2)'(mod_tab[3][{1'b0, la_val[l][30:24]}]);
      if (mod_sum[l] >= WIN_X2) begin
        mod_sum[l] = mod_sum[l] - WIN_X2;
      end
      if (mod_sum[l] >= WIN_X1) begin
        mod_sum[l] = mod_sum[l] - WIN_X1;
      end
      draw_val[l] = mod_sum[l][BW-1:0] + 1'b1;
    end
  end

  assign pm_src = pm_reload ? seed : pm_la2;
  assign pm_m1  = csmabs_pkg::pm_mulmod(pm_src, csmabs_pkg::PM_A1);
  assign pm_m2  = csmabs_pkg::pm_mulmod(pm_src, csmabs_pkg::PM_A2);

  always_comb begin
    head_ptr_next     = head_ptr;
    tail_ptr_next     = tail_ptr;
    held_count_next   = held_count;
    retry_count_next  = retry_count;
    backoff_left_next = backoff_left;
    phase_next        = phase;
    tag_wr            = 1'b0;
    pm_steps          = 2'd0;
    status            = csmabs_pkg::ST_NONE;
    tag_out           = '0;
    is_retry          = 1'b0;
    failed            = 1'b0;
    retry_inc         = (retry_count < csmabs_pkg::RETRY_SAT) ? retry_count + 1'b1
                                                              : retry_count;
    case (in_op)
      csmabs_pkg::OP_ARRIVE: begin
        tag_out = in_tag;
        if (held_count == CNT_FULL) begin
          status = csmabs_pkg::ST_DROP_FULL;
        end else begin
          tag_wr          = 1'b1;
          tail_ptr_next   = (tail_ptr == PTR_LAST) ? '0 : tail_ptr + 1'b1;
          held_count_next = held_count + 1'b1;
          status          = csmabs_pkg::ST_QUEUED;
          if (phase == csmabs_pkg::PH_IDLE) begin
            retry_count_next  = '0;
            backoff_left_next = draw_val[0];
            phase_next        = csmabs_pkg::PH_BACKOFF;
            pm_steps          = 2'd1;
          end
        end
      end
      csmabs_pkg::OP_CHECK: begin
        if (phase == csmabs_pkg::PH_BACKOFF && !in_busy) begin
          if (backoff_left == '0) begin
            phase_next = csmabs_pkg::PH_TX;
            status     = csmabs_pkg::ST_TX_START;
            tag_out    = head_tag;
            is_retry   = (retry_count != '0);
          end else begin
            backoff_left_next = backoff_left - 1'b1;
          end
        end
      end
      csmabs_pkg::OP_OUTCOME: begin
        if (phase == csmabs_pkg::PH_TX) begin
          tag_out = head_tag;
          failed  = in_coll || (pm_la1 < err_thresh);
          if (!failed || retry_inc > {1'b0, max_retries}) begin
            status           = failed ? csmabs_pkg::ST_DROP_LIMIT : csmabs_pkg::ST_DELIVERED;
            head_ptr_next    = (head_ptr == PTR_LAST) ? '0 : head_ptr + 1'b1;
            held_count_next  = held_count - 1'b1;
            retry_count_next = '0;
            if (held_count != CW'(1)) begin
              backoff_left_next = in_coll ? draw_val[0] : draw_val[1];
              phase_next        = csmabs_pkg::PH_BACKOFF;
              pm_steps          = in_coll ? 2'd1 : 2'd2;
            end else begin
              backoff_left_next = '0;
              phase_next        = csmabs_pkg::PH_IDLE;
              pm_steps          = in_coll ? 2'd0 : 2'd1;
            end
          end else begin
            status            = csmabs_pkg::ST_RETRY;
            retry_count_next  = retry_inc;
            backoff_left_next = in_coll ? draw_val[0] : draw_val[1];
            phase_next        = csmabs_pkg::PH_BACKOFF;
            pm_steps          = in_coll ? 2'd1 : 2'd2;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_retries <= csmabs_pkg::MAX_RETRIES_RST;
      seed        <= csmabs_pkg::SEED_RST;
      err_thresh  <= csmabs_pkg::ERR_THRESH_RST;
      pm_reload   <= 1'b1;
    end else begin
      pm_reload <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          csmabs_pkg::REG_MAX_RETRIES: max_retries <= cfg_data[3:0];
          csmabs_pkg::REG_SEED: begin
            seed      <= cfg_data;
            pm_reload <= 1'b1;
          end
          csmabs_pkg::REG_ERR_THRESH:  err_thresh <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pm_reload) begin
      pm_la1 <= pm_m1;
      pm_la2 <= pm_m2;
    end else if (proc) begin
      case (pm_steps)
        2'd1: begin
          pm_la1 <= pm_la2;
          pm_la2 <= pm_m1;
        end
        2'd2: begin
          pm_la1 <= pm_m1;
          pm_la2 <= pm_m2;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_tag  <= s_tdata[15:0];
      in_busy <= s_tdata[16];
      in_coll <= s_tdata[17];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr     <= '0;
      tail_ptr     <= '0;
      held_count   <= '0;
      retry_count  <= '0;
      backoff_left <= '0;
      phase        <= csmabs_pkg::PH_IDLE;
    end else if (proc) begin
      head_ptr     <= head_ptr_next;
      tail_ptr     <= tail_ptr_next;
      held_count   <= held_count_next;
      retry_count  <= retry_count_next;
      backoff_left <= backoff_left_next;
      phase        <= phase_next;
    end
  end

  // tag queue with registered head read, write-first on the same entry
  always_ff @(posedge clk) begin
    if (proc && tag_wr) begin
      tag_mem[tail_ptr] <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && tag_wr && tail_ptr == head_ptr_next) begin
      head_tag <= in_tag;
    end else if (proc) begin
      head_tag <= tag_mem[head_ptr_next];
    end else begin
      head_tag <= tag_mem[head_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (proc) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_status  <= status;
      out_tag     <= tag_out;
      out_retry   <= is_retry;
      out_count   <= 4'(held_count_next);
      out_retries <= retry_count_next;
    end
  end

  assign m_tvalid = out_full;
  assign m_tuser  = out_status;
  assign m_tdata  = {6'd0, out_retries, out_count, out_retry, out_tag};

endmodule

// ===== rtl/csmabs_checker.sv =====
// ----------------------------------------------------------------------------
// csmabs_checker
// Port-level checks on the result stream of the CSMA backoff station.
// ----------------------------------------------------------------------------
module csmabs_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  a_none_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == csmabs_pkg::ST_NONE |-> m_tdata[16:0] == 17'd0)
    else $error("ignored word carries a tag or retry flag");

  a_retry_flag_on_start: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[16] |-> m_tuser == csmabs_pkg::ST_TX_START)
    else $error("retry flag outside a transmit start");

  a_finish_clears_retries: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == csmabs_pkg::ST_DELIVERED || m_tuser == csmabs_pkg::ST_DROP_LIMIT)
    |-> m_tdata[25:21] == 5'd0)
    else $error("retry count not cleared when head leaves");

endmodule

bind csma_backoff_station_unit csmabs_checker u_csmabs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/sv/csma_backoff_station_unit_tb.sv =====
// ----------------------------------------------------------------------------
// csma_backoff_station_unit_tb
// Self-checking bench for the CSMA backoff station. A directed table covers
// the idle, full-queue, collision and retry corners. Random words follow
// under several register settings, from stuck and extreme seeds to
// never-fail and always-fail error thresholds. Every result word is checked
// field by field against a local model of the queue, backoff and retry
// logic. Both stream sides idle at random, and the result side holds off
// once for a long stretch.
// ----------------------------------------------------------------------------
module csma_backoff_station_unit_tb;

  localparam int QDEPTH = 10;
  localparam int WINDOW = 16;
  localparam int STALL_LIMIT = 2000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    csmabs_pkg::status_t status;
    logic [15:0]         tag;
    logic                retry;
    logic [3:0]          qcnt;
    logic [4:0]          rnow;
  } station_word_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [15:0]   tag;
    logic          busy;
    logic          coll;
    logic [7:0]    reps;
    logic          typed;
    station_word_t want;
  } stim_row_t;

  typedef struct {
    logic [3:0]  mr;
    logic [30:0] sd;
    logic [30:0] th;
    int          arr_pct;
    int          n;
  } phase_plan_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;

  csma_backoff_station_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // station model state
  logic [15:0]        q_tags [QDEPTH];
  int unsigned        q_head, q_tail, q_held;
  logic [4:0]         retries;
  logic [4:0]         backoff;
  csmabs_pkg::phase_t phase;
  logic [30:0]        rng;
  logic [3:0]         max_r;
  logic [30:0]        thresh;

  station_word_t pending_words [$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int tx_calm = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [30:0] next_rand();
    longint unsigned prod;
    prod = longint'(rng) * 64'd16807;
    rng = 31'(prod % longint'(csmabs_pkg::PM_MOD));
    return rng;
  endfunction

  function automatic void draw_backoff();
    logic [30:0] r;
    r = next_rand();
    backoff = 5'((r % WINDOW) + 1);
    phase = csmabs_pkg::PH_BACKOFF;
  endfunction

  function automatic void retire_head();
    q_head = (q_head + 1) % QDEPTH;
    q_held = q_held - 1;
    retries = '0;
    if (q_held > 0) begin
      draw_backoff();
    end else begin
      backoff = '0;
      phase = csmabs_pkg::PH_IDLE;
    end
  endfunction

  function automatic void advance_station(input logic [1:0] op, input logic [15:0] tag_in,
                                          input logic busy, input logic coll,
                                          output station_word_t w);
    logic failed;
    w.status = csmabs_pkg::ST_NONE;
    w.tag = '0;
    w.retry = 1'b0;
    case (op)
      csmabs_pkg::OP_ARRIVE: begin
        w.tag = tag_in;
        if (q_held >= QDEPTH) begin
          w.status = csmabs_pkg::ST_DROP_FULL;
        end else begin
          q_tags[q_tail] = tag_in;
          q_tail = (q_tail + 1) % QDEPTH;
          q_held = q_held + 1;
          w.status = csmabs_pkg::ST_QUEUED;
          if (phase == csmabs_pkg::PH_IDLE) begin
            retries = '0;
            draw_backoff();
          end
        end
      end
      csmabs_pkg::OP_CHECK: begin
        if (phase == csmabs_pkg::PH_BACKOFF && !busy) begin
          if (backoff == 0) begin
            phase = csmabs_pkg::PH_TX;
            w.status = csmabs_pkg::ST_TX_START;
            w.tag = q_tags[q_head];
            w.retry = (retries != 0);
          end else begin
            backoff = backoff - 1'b1;
          end
        end
      end
      csmabs_pkg::OP_OUTCOME: begin
        if (phase == csmabs_pkg::PH_TX) begin
          w.tag = q_tags[q_head];
          failed = coll;
          if (!failed) begin
            failed = (next_rand() < thresh);
          end
          if (!failed) begin
            w.status = csmabs_pkg::ST_DELIVERED;
            retire_head();
          end else begin
            if (retries < csmabs_pkg::RETRY_SAT) begin
              retries = retries + 1'b1;
            end
            if (retries > {1'b0, max_r}) begin
              w.status = csmabs_pkg::ST_DROP_LIMIT;
              retire_head();
            end else begin
              w.status = csmabs_pkg::ST_RETRY;
              draw_backoff();
            end
          end
        end
      end
      default: ;
    endcase
    w.qcnt = 4'(q_held);
    w.rnow = retries;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic stim_row_t row(logic [1:0] op, logic [15:0] tag, logic busy,
                                    logic coll, int reps);
    stim_row_t s;
    s = '0;
    s.op = op;
    s.tag = tag;
    s.busy = busy;
    s.coll = coll;
    s.reps = 8'(reps);
    s.want.status = csmabs_pkg::ST_NONE;
    return s;
  endfunction

  function automatic stim_row_t typed_row(logic [1:0] op, logic [15:0] tag, logic busy,
                                          logic coll, csmabs_pkg::status_t st,
                                          logic [15:0] wtag, logic [3:0] qcnt,
                                          logic [4:0] rnow);
    stim_row_t s;
    s = row(op, tag, busy, coll, 1);
    s.typed = 1'b1;
    s.want.status = st;
    s.want.tag = wtag;
    s.want.retry = 1'b0;
    s.want.qcnt = qcnt;
    s.want.rnow = rnow;
    return s;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch on result word %0d, %s: got 0x%0h, want 0x%0h",
             words_out, field, got, want);
    errors++;
  endtask

  task automatic send_word(logic [1:0] op, logic [15:0] tag, logic busy, logic coll);
    int gap;
    if (tx_calm > 0) begin
      gap = 0;
      tx_calm--;
    end else begin
      gap = draw_gap();
      if ($urandom_range(0, 49) == 0) begin
        tx_calm = $urandom_range(20, 80);
      end
    end
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {6'd0, coll, busy, tag};
    do @(posedge clk); while (!s_tready);
    words_in++;
  endtask

  task automatic offer_word(logic [1:0] op, logic [15:0] tag, logic busy, logic coll);
    station_word_t w;
    advance_station(op, tag, busy, coll, w);
    pending_words.insert(pending_words.size(), w);
    send_word(op, tag, busy, coll);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(logic [3:0] mr, logic [30:0] sd, logic [30:0] th);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= csmabs_pkg::REG_MAX_RETRIES;
    cfg_data <= {27'd0, mr};
    @(negedge clk);
    cfg_index <= csmabs_pkg::REG_SEED;
    cfg_data <= sd;
    @(negedge clk);
    cfg_index <= csmabs_pkg::REG_ERR_THRESH;
    cfg_data <= th;
    @(negedge clk);
    cfg_we <= 1'b0;
    max_r = mr;
    rng = sd;
    thresh = th;
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random(int arr_pct, int n);
    int done_n;
    int r;
    logic [1:0] op;
    done_n = 0;
    while (done_n < n) begin
      r = $urandom_range(0, 99);
      if (r < arr_pct) begin
        op = csmabs_pkg::OP_ARRIVE;
      end else if (r < arr_pct + 4) begin
        op = OP_UNUSED;
      end else if (phase == csmabs_pkg::PH_TX) begin
        op = ($urandom_range(0, 9) < 7) ? csmabs_pkg::OP_OUTCOME : csmabs_pkg::OP_CHECK;
      end else begin
        op = ($urandom_range(0, 9) == 0) ? csmabs_pkg::OP_OUTCOME : csmabs_pkg::OP_CHECK;
      end
      offer_word(op, 16'($urandom), ($urandom_range(0, 3) == 0),
                 ($urandom_range(0, 2) == 0));
      done_n++;
    end
  endtask

  // result side: random gaps, calm stretches, one long hold-off
  initial begin : rx_side
    int rx_wait;
    int rx_calm;
    bit held_off;
    rx_wait = 0;
    rx_calm = 0;
    held_off = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && words_in >= 400) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end else if (rx_wait > 0) begin
        m_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_tready <= 1'b1;
        if (rx_calm > 0) begin
          rx_calm--;
        end else begin
          rx_wait = draw_gap();
          if ($urandom_range(0, 59) == 0) begin
            rx_calm = $urandom_range(30, 120);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    station_word_t e;
    if (m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", {m_tuser, m_tdata}, 0);
      end else begin
        e = pending_words.pop_front();
        if (m_tuser != e.status) report_mismatch("status", m_tuser, e.status);
        if (m_tdata[15:0] != e.tag) report_mismatch("tx_tag", m_tdata[15:0], e.tag);
        if (m_tdata[16] != e.retry) report_mismatch("tx_is_retry", m_tdata[16], e.retry);
        if (m_tdata[20:17] != e.qcnt) report_mismatch("queue_count", m_tdata[20:17], e.qcnt);
        if (m_tdata[25:21] != e.rnow) report_mismatch("retries_now", m_tdata[25:21], e.rnow);
      end
      words_out++;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    stim_row_t dir_rows [$];
    phase_plan_t plans [$];
    station_word_t w;
    q_head = 0;
    q_tail = 0;
    q_held = 0;
    retries = '0;
    backoff = '0;
    phase = csmabs_pkg::PH_IDLE;
    max_r = csmabs_pkg::MAX_RETRIES_RST;
    rng = csmabs_pkg::SEED_RST;
    thresh = csmabs_pkg::ERR_THRESH_RST;
    foreach (q_tags[i]) q_tags[i] = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (4) @(negedge clk);

    dir_rows = '{
      typed_row(csmabs_pkg::OP_CHECK, 16'h0000, 1'b0, 1'b0,
                csmabs_pkg::ST_NONE, 16'h0000, 4'd0, 5'd0),
      typed_row(csmabs_pkg::OP_OUTCOME, 16'hFFFF, 1'b1, 1'b1,
                csmabs_pkg::ST_NONE, 16'h0000, 4'd0, 5'd0),
      typed_row(OP_UNUSED, 16'hFFFF, 1'b1, 1'b1,
                csmabs_pkg::ST_NONE, 16'h0000, 4'd0, 5'd0),
      typed_row(csmabs_pkg::OP_ARRIVE, 16'hFFFF, 1'b1, 1'b1,
                csmabs_pkg::ST_QUEUED, 16'hFFFF, 4'd1, 5'd0),
      typed_row(csmabs_pkg::OP_ARRIVE, 16'h0000, 1'b0, 1'b0,
                csmabs_pkg::ST_QUEUED, 16'h0000, 4'd2, 5'd0),
      row(csmabs_pkg::OP_OUTCOME, 16'h5A5A, 1'b0, 1'b1, 1),
      row(csmabs_pkg::OP_CHECK,   16'h0000, 1'b1, 1'b0, 2),
      row(csmabs_pkg::OP_CHECK,   16'h0000, 1'b0, 1'b0, 9),
      row(csmabs_pkg::OP_OUTCOME, 16'h0000, 1'b0, 1'b1, 1),
      row(csmabs_pkg::OP_CHECK,   16'hFFFF, 1'b0, 1'b1, 3),
      row(csmabs_pkg::OP_OUTCOME, 16'hFFFF, 1'b1, 1'b0, 1),
      row(csmabs_pkg::OP_ARRIVE,  16'hA000, 1'b0, 1'b0, 10)
    };
    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].reps; k++) begin
        advance_station(dir_rows[i].op, dir_rows[i].tag + 16'(k), dir_rows[i].busy,
                        dir_rows[i].coll, w);
        pending_words.insert(pending_words.size(), dir_rows[i].typed ? dir_rows[i].want : w);
        send_word(dir_rows[i].op, dir_rows[i].tag + 16'(k), dir_rows[i].busy,
                  dir_rows[i].coll);
      end
    end
    drain();

    plans = '{
      '{4'd0,  31'h7FFFFFFF, 31'd2147484,    25, 200},
      '{4'd15, 31'd12345,    31'd0,          10, 300},
      '{4'd15, 31'h7FFFFFFE, 31'h7FFFFFFF,   30, 300},
      '{4'd3,  31'd1,        31'h40000000,   45, 300},
      '{4'd7,  31'd0,        31'd0,          20, 220}
    };
    plans[3].sd = 31'($urandom_range(1, 32'h7FFFFFFE));
    foreach (plans[p]) begin
      load_settings(plans[p].mr, plans[p].sd, plans[p].th);
      run_random(plans[p].arr_pct, plans[p].n);
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
